// File: rtl/core/ring_of_writes_offset_lookup_macros.svh
// assertion macros for the ring lookup block
// used by the top level; needs a clock named clock and a reset named reset in scope
`ifndef RING_OF_WRITES_OFFSET_LOOKUP_MACROS_SVH
`define RING_OF_WRITES_OFFSET_LOOKUP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ROWOL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rowol: same-cycle check failed");

// next-cycle implication, checked outside reset
`define ROWOL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rowol: next-cycle check failed");

`endif

// File: rtl/core/rowol_pkg.sv
// shared types, constants and helpers for the ring lookup block
// no dependencies; imported by the interfaces and every module
package rowol_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 16;
   localparam int OFFS_W   = 20;
   localparam int INDEX_W  = 4;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_FIND = 1'b1;

   typedef logic [IDX_W-1:0] rowol_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } rowol_state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
   } rowol_slot_type;

   typedef struct packed {
      logic           we;
      rowol_idx_type  waddr;
      rowol_slot_type wdata;
      rowol_idx_type  raddr;
   } rowol_ram_cmd_type;

   typedef struct packed {
      logic                found;
      logic [HANDLE_W-1:0] handle;
      logic [INDEX_W-1:0]  index;
      logic [SIZE_W-1:0]   offset;
   } rowol_result_type;

   // advance a ring pointer, wrapping at the last slot
   function automatic rowol_idx_type next_slot(input rowol_idx_type idx);
      next_slot = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
   endfunction

   // slot number as reported: masked to the narrow index field
   function automatic logic [INDEX_W-1:0] to_index(input rowol_idx_type idx);
      logic [IDX_W+INDEX_W-1:0] wide;
      wide = {{INDEX_W{1'b0}}, idx};
      to_index = wide[INDEX_W-1:0];
   endfunction

endpackage

// File: rtl/core/rowol_if.sv
// request and response channel interfaces for the ring lookup block
// depends on rowol_pkg for field widths
interface rowol_req_if;
   import rowol_pkg::*;
   logic                valid;
   logic                ready;
   logic                opcode;
   logic [HANDLE_W-1:0] entry_handle;
   logic [SIZE_W-1:0]   entry_size;
   logic [OFFS_W-1:0]   seek_offset;

   modport source (output valid, output opcode, output entry_handle, output entry_size,
                   output seek_offset, input ready);
   modport sink (input valid, input opcode, input entry_handle, input entry_size,
                 input seek_offset, output ready);
endinterface

interface rowol_rsp_if;
   import rowol_pkg::*;
   logic                valid;
   logic                ready;
   logic                found;
   logic [HANDLE_W-1:0] hit_handle;
   logic [INDEX_W-1:0]  hit_index;
   logic [SIZE_W-1:0]   byte_offset;

   modport source (output valid, output found, output hit_handle, output hit_index,
                   output byte_offset, input ready);
   modport sink (input valid, input found, input hit_handle, input hit_index,
                 input byte_offset, output ready);
endinterface

// File: rtl/core/rowol_ram.sv
// slot memory: handle and length per ring slot, one write and one read port
// depends on rowol_pkg; read data registered
module rowol_ram (
   input  logic                         clock,
   input  rowol_pkg::rowol_ram_cmd_type cmd,
   output rowol_pkg::rowol_slot_type    rd_data
);
   import rowol_pkg::*;

   rowol_slot_type mem [DEPTH];
   rowol_slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
      rd_data_ff <= mem[cmd.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/rowol_ctrl.sv
// ring pointers and the find sequencer walking the slot memory
// depends on rowol_pkg, rowol_if; drives rowol_ram
module rowol_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   rowol_req_if.sink                    req_chan,
   output rowol_pkg::rowol_ram_cmd_type ram_cmd,
   input  rowol_pkg::rowol_slot_type    ram_data,
   output logic                         res_valid,
   output rowol_pkg::rowol_result_type  res_data,
   input  logic                         res_take
);
   import rowol_pkg::*;

   rowol_state_type  state_ff, state_in;
   rowol_idx_type    wr_ptr_ff, wr_ptr_in;
   rowol_idx_type    rd_ptr_ff, rd_ptr_in;
   logic             full_ff, full_in;
   rowol_idx_type    cur_idx_ff, cur_idx_in;
   rowol_idx_type    left_ff, left_in;
   logic [OFFS_W-1:0] offs_ff, offs_in;
   rowol_result_type res_ff, res_in;

   logic             accept;
   logic             empty;
   logic [IDX_W:0]   used_cnt;
   logic [IDX_W:0]   used_less1;
   rowol_idx_type    wr_next;
   logic             slot_hit;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      empty = !full_ff && (wr_ptr_ff == rd_ptr_ff);
      if (full_ff) begin
         used_cnt = (IDX_W+1)'(DEPTH);
      end else if (wr_ptr_ff >= rd_ptr_ff) begin
         used_cnt = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      end else begin
         used_cnt = {1'b0, wr_ptr_ff} + (IDX_W+1)'(DEPTH) - {1'b0, rd_ptr_ff};
      end
      used_less1 = used_cnt - (IDX_W+1)'(1);
      wr_next    = next_slot(wr_ptr_ff);
      slot_hit   = offs_ff < {{(OFFS_W-SIZE_W){1'b0}}, ram_data.size};
   end

   always_comb begin
      ram_cmd.we           = accept && (req_chan.opcode == OP_ADD);
      ram_cmd.waddr        = wr_ptr_ff;
      ram_cmd.wdata.handle = req_chan.entry_handle;
      ram_cmd.wdata.size   = req_chan.entry_size;
      // during the walk fetch the following slot ahead of the compare
      ram_cmd.raddr        = (state_ff == ST_WALK) ? next_slot(cur_idx_ff) : rd_ptr_ff;
   end

   always_comb begin
      state_in   = state_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      full_in    = full_ff;
      cur_idx_in = cur_idx_ff;
      left_in    = left_ff;
      offs_in    = offs_ff;
      res_in     = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_chan.opcode == OP_ADD)) begin
               wr_ptr_in = wr_next;
               if (full_ff) begin
                  rd_ptr_in = wr_next;
               end else if (wr_next == rd_ptr_ff) begin
                  full_in = 1'b1;
               end
            end else if (accept) begin
               cur_idx_in = rd_ptr_ff;
               left_in    = used_less1[IDX_W-1:0];
               offs_in    = req_chan.seek_offset;
               res_in     = '0;
               state_in   = empty ? ST_DONE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (slot_hit) begin
               res_in.found  = 1'b1;
               res_in.handle = ram_data.handle;
               res_in.index  = to_index(cur_idx_ff);
               res_in.offset = offs_ff[SIZE_W-1:0];
               state_in      = ST_DONE;
            end else if (left_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               offs_in    = offs_ff - {{(OFFS_W-SIZE_W){1'b0}}, ram_data.size};
               cur_idx_in = next_slot(cur_idx_ff);
               left_in    = left_ff - IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         full_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         full_ff   <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff <= cur_idx_in;
      left_ff    <= left_in;
      offs_ff    <= offs_in;
      res_ff     <= res_in;
   end

   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

endmodule

// File: rtl/core/ring_of_writes_offset_lookup.sv
// top level of the ring lookup block: sequencer, slot memory, response register
// depends on rowol_pkg, rowol_if, rowol_ram, rowol_ctrl and the macro header
//
//   channel   dir  beat
//   req_chan  in   opcode, entry_handle, entry_size, seek_offset
//   rsp_chan  out  found, hit_handle, hit_index, byte_offset (one per find)
//
// back-to-back adds are accepted every cycle while no find is in progress
// a find blocks requests until the response register takes its result; it
// walks from the oldest entry to a hit or the newest entry (none if empty),
// the single read port of the slot memory visiting one entry per cycle
// reset (synchronous) empties the ring; slot contents are not cleared
// the response register lets the next item in while a result waits on rsp_chan
`include "ring_of_writes_offset_lookup_macros.svh"

module ring_of_writes_offset_lookup (
   input  logic        clock,
   input  logic        reset,
   rowol_req_if.sink   req_chan,
   rowol_rsp_if.source rsp_chan
);
   import rowol_pkg::*;

   rowol_ram_cmd_type ram_cmd;
   rowol_slot_type    ram_data;
   logic              res_valid;
   rowol_result_type  res_data;
   logic              res_take;

   logic              out_valid_ff, out_valid_in;
   rowol_result_type  out_ff;
   logic              out_payload_zero;

   // sequencer and ring pointers
   rowol_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .ram_cmd  (ram_cmd),
      .ram_data (ram_data),
      .res_valid(res_valid),
      .res_data (res_data),
      .res_take (res_take)
   );

   // handle and length per slot
   rowol_ram u_ram (
      .clock  (clock),
      .cmd    (ram_cmd),
      .rd_data(ram_data)
   );

   // response register: load when empty or being drained this cycle
   assign res_take = res_valid && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_take) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (res_take) begin
         out_ff <= res_data;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.found       = out_ff.found;
   assign rsp_chan.hit_handle  = out_ff.handle;
   assign rsp_chan.hit_index   = out_ff.index;
   assign rsp_chan.byte_offset = out_ff.offset;

   assign out_payload_zero = (out_ff.handle == '0) && (out_ff.index == '0) &&
                             (out_ff.offset == '0);

   // a miss carries an all-zero payload
   `ROWOL_ASSERT_NOW(a_miss_zero, out_valid_ff && !out_ff.found, out_payload_zero)
   // an accepted find blocks the request side on the next cycle
   `ROWOL_ASSERT_NEXT(a_find_blocks, req_chan.valid && req_chan.ready && (req_chan.opcode == OP_FIND), !req_chan.ready)
   // a result handed to the response register shows up there next cycle
   `ROWOL_ASSERT_NEXT(a_take_shows, res_take, rsp_chan.valid)

endmodule
